/* rtl/qrr_pkg.sv */
package qrr_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_DOUBLE   = 2'd1,
    ST_DISTINCT = 2'd2,
    ST_A_ZERO   = 2'd3
  } qrr_status_t;

  // Flags carried beside the divider lanes
  typedef struct packed {
    logic a_neg;   // coefficient a is negative
    logic a_zero;  // coefficient a is zero
    logic d_neg;   // discriminant is negative
    logic s_zero;  // square root of discriminant is zero
    logic sgn_m;   // sign of the (-b - s) quotient
    logic sgn_p;   // sign of the (-b + s) quotient
  } qrr_side_t;

endpackage

/* rtl/quadratic_real_root_solver.sv */
// Real roots of a*x^2 + b*x + c from signed fixed-point coefficients. The block
// is fully pipelined: busy stays low, so a coefficient set may be started on
// every clock, and each set yields exactly one result on out_valid. A set
// passes in order through the multiply register, the discriminant register,
// the square-root row (one cell per root bit, COEF_WIDTH+1 cells), the numerator
// register, the long-division row (one cell per quotient bit,
// COEF_WIDTH+1+ROOT_WIDTH/2 cells) and the output register. out_valid pulses
// for one cycle per result and the receiver must take it then: there is no
// backpressure. Roots are in Q16.16 (ROOT_WIDTH/2 fraction bits), truncated
// toward zero, saturated, smaller root first; status 0 none, 1 double, 2
// distinct, 3 a is zero.
module quadratic_real_root_solver
  import qrr_pkg::*;
#(
  parameter int COEF_WIDTH = 16,
  parameter int ROOT_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COEF_WIDTH-1:0] in_coef_a,
  input  logic signed [COEF_WIDTH-1:0] in_coef_b,
  input  logic signed [COEF_WIDTH-1:0] in_coef_c,
  output logic                         out_valid,
  output logic signed [ROOT_WIDTH-1:0] out_root_low,
  output logic signed [ROOT_WIDTH-1:0] out_root_high,
  output logic [1:0]                   out_root_status
);

  localparam int W    = COEF_WIDTH;
  localparam int DW   = 2 * W + 3;          // signed discriminant
  localparam int RB   = W + 1;              // root bits
  localparam int SW   = 2 * RB;             // radicand bits
  localparam int SBS  = 2 * W + 2;          // sqrt sideband
  localparam int NW   = W + 2;              // signed numerator
  localparam int F    = ROOT_WIDTH / 2;
  localparam int QB   = (NW - 1) + F;       // quotient bits
  localparam int DNW  = W + 1;              // divisor bits
  localparam int XW   = ((QB > ROOT_WIDTH) ? QB : ROOT_WIDTH) + 1;

  // Stage 1: products
  logic                  v1_r;
  logic signed [W-1:0]   a1_r, b1_r;
  logic signed [2*W-1:0] bb1_r, ac1_r;

  // Stage 2: discriminant
  logic                  v2_r;
  logic signed [DW-1:0]  d_nxt;
  logic [SW-1:0]         rad2_r;
  logic [SBS-1:0]        side2_r;

  // Square-root row
  logic              s_vld  [0:RB];
  logic [SW-1:0]     s_rad  [0:RB];
  logic [RB+2:0]     s_rem  [0:RB];
  logic [RB-1:0]     s_root [0:RB];
  logic [SBS-1:0]    s_side [0:RB];

  // Numerator stage
  logic signed [W-1:0] a_s, b_s;
  logic                az_s, dn_s;
  logic signed [NW-1:0] nm_nxt, np_nxt;
  logic [NW-2:0]       mm_nxt, mp_nxt;
  logic                v3_r;
  logic [DNW-1:0]      den3_r;
  logic [QB-1:0]       nm3_r, np3_r;
  qrr_side_t           side3_r;

  // Division row
  logic              q_vld  [0:QB];
  logic [DNW-1:0]    q_den  [0:QB];
  logic [QB-1:0]     q_nm   [0:QB];
  logic [QB-1:0]     q_np   [0:QB];
  logic [DNW-1:0]    q_rm   [0:QB];
  logic [DNW-1:0]    q_rp   [0:QB];
  logic [QB-1:0]     q_qm   [0:QB];
  logic [QB-1:0]     q_qp   [0:QB];
  qrr_side_t         q_side [0:QB];

  // Output stage
  logic signed [ROOT_WIDTH-1:0] rm_fin, rp_fin;
  logic                         ov_r;
  logic signed [ROOT_WIDTH-1:0] lo_r, hi_r, lo_nxt, hi_nxt;
  qrr_status_t                  st_r, st_nxt;

  assign busy = 1'b0;

  // Hold the valid bits of the fixed stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= s_vld[RB];
      ov_r <= q_vld[QB];
    end
  end

  // Form b*b and a*c
  always_ff @(posedge clk) begin
    a1_r  <= in_coef_a;
    b1_r  <= in_coef_b;
    bb1_r <= in_coef_b * in_coef_b;
    ac1_r <= in_coef_a * in_coef_c;
  end

  // Discriminant; clamp the radicand to zero when negative
  assign d_nxt = DW'(bb1_r) - (DW'(ac1_r) <<< 2);

  always_ff @(posedge clk) begin
    rad2_r  <= d_nxt[DW-1] ? '0 : d_nxt[SW-1:0];
    side2_r <= {a1_r, b1_r, (a1_r == '0), d_nxt[DW-1]};
  end

  assign s_vld[0]  = v2_r;
  assign s_rad[0]  = rad2_r;
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_side[0] = side2_r;

  for (genvar i = 0; i < RB; i++) begin : g_sqrt
    qrr_sqrt_cell #(
      .RAD_W  (SW),
      .ROOT_W (RB),
      .SIDE_W (SBS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (s_vld[i]),
      .in_rad   (s_rad[i]),
      .in_rem   (s_rem[i]),
      .in_root  (s_root[i]),
      .in_side  (s_side[i]),
      .out_vld  (s_vld[i+1]),
      .out_rad  (s_rad[i+1]),
      .out_rem  (s_rem[i+1]),
      .out_root (s_root[i+1]),
      .out_side (s_side[i+1])
    );
  end

  // Form the two numerators -b -/+ s as sign and magnitude
  always_comb begin
    a_s    = s_side[RB][SBS-1:W+2];
    b_s    = s_side[RB][W+1:2];
    az_s   = s_side[RB][1];
    dn_s   = s_side[RB][0];
    nm_nxt = -NW'(b_s) - $signed({1'b0, s_root[RB]});
    np_nxt = -NW'(b_s) + $signed({1'b0, s_root[RB]});
    mm_nxt = nm_nxt[NW-1] ? (NW-1)'(-nm_nxt) : nm_nxt[NW-2:0];
    mp_nxt = np_nxt[NW-1] ? (NW-1)'(-np_nxt) : np_nxt[NW-2:0];
  end

  always_ff @(posedge clk) begin
    den3_r         <= a_s[W-1] ? DNW'(-(DNW'(a_s) <<< 1)) : DNW'(DNW'(a_s) <<< 1);
    nm3_r          <= {mm_nxt, {F{1'b0}}};
    np3_r          <= {mp_nxt, {F{1'b0}}};
    side3_r.a_neg  <= a_s[W-1];
    side3_r.a_zero <= az_s;
    side3_r.d_neg  <= dn_s;
    side3_r.s_zero <= (s_root[RB] == '0);
    side3_r.sgn_m  <= nm_nxt[NW-1] ^ a_s[W-1];
    side3_r.sgn_p  <= np_nxt[NW-1] ^ a_s[W-1];
  end

  assign q_vld[0]  = v3_r;
  assign q_den[0]  = den3_r;
  assign q_nm[0]   = nm3_r;
  assign q_np[0]   = np3_r;
  assign q_rm[0]   = '0;
  assign q_rp[0]   = '0;
  assign q_qm[0]   = '0;
  assign q_qp[0]   = '0;
  assign q_side[0] = side3_r;

  for (genvar j = 0; j < QB; j++) begin : g_div
    qrr_div_cell #(
      .NUM_W (QB),
      .DEN_W (DNW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_vld    (q_vld[j]),
      .in_den    (q_den[j]),
      .in_num_m  (q_nm[j]),
      .in_num_p  (q_np[j]),
      .in_rem_m  (q_rm[j]),
      .in_rem_p  (q_rp[j]),
      .in_quo_m  (q_qm[j]),
      .in_quo_p  (q_qp[j]),
      .in_side   (q_side[j]),
      .out_vld   (q_vld[j+1]),
      .out_den   (q_den[j+1]),
      .out_num_m (q_nm[j+1]),
      .out_num_p (q_np[j+1]),
      .out_rem_m (q_rm[j+1]),
      .out_rem_p (q_rp[j+1]),
      .out_quo_m (q_qm[j+1]),
      .out_quo_p (q_qp[j+1]),
      .out_side  (q_side[j+1])
    );
  end

  // Apply sign and saturate one quotient magnitude
  function automatic logic [ROOT_WIDTH-1:0] fin_root(input logic [QB-1:0] mag,
                                                     input logic neg);
    logic [XW-1:0] m;
    logic [XW-1:0] lim;
    logic [XW-1:0] res;
    m   = XW'(mag);
    lim = XW'({1'b0, {(ROOT_WIDTH-1){1'b1}}});
    if (neg) begin
      res = (m > lim) ? ~lim : -m;
    end else begin
      res = (m > lim) ? lim : m;
    end
    return res[ROOT_WIDTH-1:0];
  endfunction

  // Order the roots and pick the status
  always_comb begin
    rm_fin = fin_root(q_qm[QB], q_side[QB].sgn_m);
    rp_fin = fin_root(q_qp[QB], q_side[QB].sgn_p);
    lo_nxt = q_side[QB].a_neg ? rp_fin : rm_fin;
    hi_nxt = q_side[QB].a_neg ? rm_fin : rp_fin;
    st_nxt = q_side[QB].s_zero ? ST_DOUBLE : ST_DISTINCT;
    if (q_side[QB].a_zero) begin
      lo_nxt = '0;
      hi_nxt = '0;
      st_nxt = ST_A_ZERO;
    end else if (q_side[QB].d_neg) begin
      lo_nxt = '0;
      hi_nxt = '0;
      st_nxt = ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    st_r <= st_nxt;
  end

  assign out_valid       = ov_r;
  assign out_root_low    = lo_r;
  assign out_root_high   = hi_r;
  assign out_root_status = st_r;

endmodule

/* rtl/qrr_sqrt_cell.sv */
module qrr_sqrt_cell #(
  parameter int RAD_W  = 34,
  parameter int ROOT_W = 17,
  parameter int SIDE_W = 34
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [RAD_W-1:0]  in_rad,
  input  logic [ROOT_W+2:0] in_rem,
  input  logic [ROOT_W-1:0] in_root,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [RAD_W-1:0]  out_rad,
  output logic [ROOT_W+2:0] out_rem,
  output logic [ROOT_W-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int REM_W = ROOT_W + 3;

  logic [REM_W-1:0]  rem2;
  logic [REM_W-1:0]  trial;
  logic              ge;
  logic              vld_r;
  logic [RAD_W-1:0]  rad_r,  rad_nxt;
  logic [REM_W-1:0]  rem_r,  rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [SIDE_W-1:0] side_r;

  // Bring down two radicand bits and try one more root bit
  always_comb begin
    rem2     = {in_rem[REM_W-3:0], in_rad[RAD_W-1:RAD_W-2]};
    trial    = {1'b0, in_root, 2'b01};
    ge       = (rem2 >= trial);
    rem_nxt  = ge ? (rem2 - trial) : rem2;
    root_nxt = {in_root[ROOT_W-2:0], ge};
    rad_nxt  = {in_rad[RAD_W-3:0], 2'b00};
  end

  // Hold valid under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  // Advance the payload to the neighbor
  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    side_r <= in_side;
  end

  assign out_vld  = vld_r;
  assign out_rad  = rad_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;
  assign out_side = side_r;

endmodule

/* rtl/qrr_div_cell.sv */
module qrr_div_cell
  import qrr_pkg::*;
#(
  parameter int NUM_W = 33,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [DEN_W-1:0] in_den,
  input  logic [NUM_W-1:0] in_num_m,
  input  logic [NUM_W-1:0] in_num_p,
  input  logic [DEN_W-1:0] in_rem_m,
  input  logic [DEN_W-1:0] in_rem_p,
  input  logic [NUM_W-1:0] in_quo_m,
  input  logic [NUM_W-1:0] in_quo_p,
  input  qrr_side_t        in_side,
  output logic             out_vld,
  output logic [DEN_W-1:0] out_den,
  output logic [NUM_W-1:0] out_num_m,
  output logic [NUM_W-1:0] out_num_p,
  output logic [DEN_W-1:0] out_rem_m,
  output logic [DEN_W-1:0] out_rem_p,
  output logic [NUM_W-1:0] out_quo_m,
  output logic [NUM_W-1:0] out_quo_p,
  output qrr_side_t        out_side
);

  logic [DEN_W:0]   r2_m, r2_p;
  logic             ge_m, ge_p;
  logic             vld_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] num_m_r, num_p_r, quo_m_r, quo_p_r;
  logic [DEN_W-1:0] rem_m_r, rem_p_r;
  logic [DEN_W-1:0] rem_m_nxt, rem_p_nxt;
  qrr_side_t        side_r;

  // Shift in one dividend bit per lane and subtract when it fits
  always_comb begin
    r2_m      = {in_rem_m, in_num_m[NUM_W-1]};
    r2_p      = {in_rem_p, in_num_p[NUM_W-1]};
    ge_m      = (r2_m >= {1'b0, in_den});
    ge_p      = (r2_p >= {1'b0, in_den});
    rem_m_nxt = ge_m ? DEN_W'(r2_m - {1'b0, in_den}) : DEN_W'(r2_m);
    rem_p_nxt = ge_p ? DEN_W'(r2_p - {1'b0, in_den}) : DEN_W'(r2_p);
  end

  // Hold valid under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  // Advance both lanes to the neighbor
  always_ff @(posedge clk) begin
    den_r   <= in_den;
    num_m_r <= {in_num_m[NUM_W-2:0], 1'b0};
    num_p_r <= {in_num_p[NUM_W-2:0], 1'b0};
    rem_m_r <= rem_m_nxt;
    rem_p_r <= rem_p_nxt;
    quo_m_r <= {in_quo_m[NUM_W-2:0], ge_m};
    quo_p_r <= {in_quo_p[NUM_W-2:0], ge_p};
    side_r  <= in_side;
  end

  assign out_vld   = vld_r;
  assign out_den   = den_r;
  assign out_num_m = num_m_r;
  assign out_num_p = num_p_r;
  assign out_rem_m = rem_m_r;
  assign out_rem_p = rem_p_r;
  assign out_quo_m = quo_m_r;
  assign out_quo_p = quo_p_r;
  assign out_side  = side_r;

endmodule

/* dv/qrr_checker.sv */
`timescale 1ns / 100ps

module qrr_checker
  import qrr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] in_coef_a,
  input  logic signed [15:0] in_coef_b,
  input  logic signed [15:0] in_coef_c,
  input  logic               out_valid,
  input  logic signed [31:0] out_root_low,
  input  logic signed [31:0] out_root_high,
  input  logic [1:0]         out_root_status,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    qrr_status_t        status;
  } root_set_t;

  localparam longint ROOT_MAX = 64'sd2147483647;
  localparam longint ROOT_MIN = -64'sd2147483648;

  root_set_t expected_roots[$];

  // Integer floor square root by bit pairs
  function automatic longint isqrt(longint v);
    longint res;
    longint bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > v) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  // Scale to Q16.16, truncate toward zero and clamp
  function automatic longint scale_root(longint num, longint den);
    longint q;
    q = (num * 65536) / den;
    if (q > ROOT_MAX) q = ROOT_MAX;
    if (q < ROOT_MIN) q = ROOT_MIN;
    return q;
  endfunction

  function automatic root_set_t solve_roots(logic signed [15:0] ca, logic signed [15:0] cb,
                                            logic signed [15:0] cc);
    root_set_t r;
    longint a, b, c, d, s, rm, rp;
    a = ca;
    b = cb;
    c = cc;
    r.lo = '0;
    r.hi = '0;
    if (a == 0) begin
      r.status = ST_A_ZERO;
    end else begin
      d = b * b - 4 * a * c;
      if (d < 0) begin
        r.status = ST_NONE;
      end else begin
        s = isqrt(d);
        rm = scale_root(-b - s, 2 * a);
        rp = scale_root(-b + s, 2 * a);
        r.lo = (a > 0) ? rm[31:0] : rp[31:0];
        r.hi = (a > 0) ? rp[31:0] : rm[31:0];
        r.status = (s > 0) ? ST_DISTINCT : ST_DOUBLE;
      end
    end
    return r;
  endfunction

  initial fail_count = 0;
  assign pending = expected_roots.size();

  // Predict on each input transfer, compare on each result transfer
  always @(posedge clk) begin
    root_set_t want;
    if (rst_n && start && !busy)
      expected_roots.push_back(solve_roots(in_coef_a, in_coef_b, in_coef_c));
    if (rst_n && out_valid) begin
      if (expected_roots.size() == 0) begin
        fail_count <= fail_count + 1;
        if (fail_count < 10) $display("unexpected result at %0t", $time);
      end else begin
        want = expected_roots.pop_front();
        if (out_root_low !== want.lo || out_root_high !== want.hi ||
            out_root_status !== want.status) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("mismatch: exp lo %0d hi %0d st %0d, got lo %0d hi %0d st %0d",
                     want.lo, want.hi, want.status, out_root_low, out_root_high,
                     out_root_status);
        end
      end
    end
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import qrr_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [15:0] in_coef_a;
  logic signed [15:0] in_coef_b;
  logic signed [15:0] in_coef_c;
  logic               out_valid;
  logic signed [31:0] out_root_low;
  logic signed [31:0] out_root_high;
  logic [1:0]         out_root_status;
  int                 fail_count;
  int                 pending;
  int                 cycles;
  int                 gap_pct;

  quadratic_real_root_solver dut (.*);

  qrr_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Abort on a hung run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 200000) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Present one coefficient set and hold it until the transfer
  task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    // Drop start while idling
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Random coefficients with bias toward small values and real roots
  task automatic send_random();
    logic [15:0] a, b, c;
    a = $urandom;
    b = $urandom;
    c = $urandom;
    case ($urandom_range(5))
      0: a = 16'(int'($urandom_range(8)) - 4);
      1: begin a = 16'(int'($urandom_range(512)) - 256); c = -a; end
      2: begin a = 16'(int'($urandom_range(64)) - 32); c = 16'(int'($urandom_range(64)) - 32); end
      3: begin b = 16'(2 * $signed(a)); c = a; end
      default: ;
    endcase
    send_coefs(a, b, c);
  endtask

  initial begin
    logic [15:0] ext[5];
    start = 0;
    in_coef_a = 0;
    in_coef_b = 0;
    in_coef_c = 0;
    rst_n = 0;
    gap_pct = 0;
    ext = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff};
    repeat (10) @(negedge clk);
    rst_n = 1;
    // Directed: corners, a zero, negative discriminant, double roots, saturation
    foreach (ext[i]) send_coefs(ext[i], ext[(i + 1) % 5], ext[(i + 3) % 5]);
    send_coefs(16'h0000, 16'h0100, 16'h0100);
    send_coefs(16'h0100, 16'h0000, 16'h0100);
    send_coefs(16'h0100, 16'hfe00, 16'h0100);
    send_coefs(16'hff00, 16'h0200, 16'hff00);
    send_coefs(16'h0001, 16'h7fff, 16'h0000);
    send_coefs(16'h0001, 16'h8000, 16'h0000);
    send_coefs(16'h0001, 16'h0000, 16'h8000);
    send_coefs(16'hffff, 16'h0000, 16'h7fff);
    send_coefs(16'h0100, 16'hfd00, 16'h0200);
    send_coefs(16'h8000, 16'h8000, 16'h8000);
    send_coefs(16'h7fff, 16'h7fff, 16'h8000);
    send_coefs(16'h0003, 16'h0005, 16'hfff9);
    // Random in three pacing phases
    gap_pct = 32;
    repeat (200) send_random();
    gap_pct = 72;
    repeat (200) send_random();
    gap_pct = 0;
    repeat (200) send_random();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
